/* design/mbu16_pkg.sv */
// package for the multibyte to utf-16 decoder: shared types, constants
// and the single-byte code page tables; no dependencies
`timescale 1ns / 1ps

package mbu16_pkg;

    localparam int UNITS_MAX = 4;

    // source_encoding register codes (code three is treated as western)
    localparam logic [1:0] ENC_CYR  = 2'd0;
    localparam logic [1:0] ENC_WEST = 2'd1;
    localparam logic [1:0] ENC_UTF8 = 2'd2;

    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [15:0] CYR_BASE     = 16'h0410;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [5:0]  LO_SURR_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    typedef logic [15:0] t_unit;
    typedef t_unit t_unit_vec [UNITS_MAX];

    // pending utf-8 sequence
    typedef struct packed {
        logic [20:0] pcp;
        logic [1:0]  need;
        logic [1:0]  taken;
    } t_seq;

    // all units caused by one input item
    typedef struct packed {
        t_unit [UNITS_MAX-1:0] units;
        logic  [2:0]           count;
    } t_dec_res;

    function automatic t_unit cyr_high(input logic [5:0] idx);
        t_unit u;
        case (idx)
            6'd0:  u = 16'h0402;  6'd1:  u = 16'h0403;  6'd2:  u = 16'h201A;
            6'd3:  u = 16'h0453;  6'd4:  u = 16'h201E;  6'd5:  u = 16'h2026;
            6'd6:  u = 16'h2020;  6'd7:  u = 16'h2021;  6'd8:  u = 16'h20AC;
            6'd9:  u = 16'h2030;  6'd10: u = 16'h0409;  6'd11: u = 16'h2039;
            6'd12: u = 16'h040A;  6'd13: u = 16'h040C;  6'd14: u = 16'h040B;
            6'd15: u = 16'h040F;  6'd16: u = 16'h0452;  6'd17: u = 16'h2018;
            6'd18: u = 16'h2019;  6'd19: u = 16'h201C;  6'd20: u = 16'h201D;
            6'd21: u = 16'h2022;  6'd22: u = 16'h2013;  6'd23: u = 16'h2014;
            6'd24: u = REPL_UNIT; 6'd25: u = 16'h2122;  6'd26: u = 16'h0459;
            6'd27: u = 16'h203A;  6'd28: u = 16'h045A;  6'd29: u = 16'h045C;
            6'd30: u = 16'h045B;  6'd31: u = 16'h045F;  6'd32: u = 16'h00A0;
            6'd33: u = 16'h040E;  6'd34: u = 16'h045E;  6'd35: u = 16'h0408;
            6'd36: u = 16'h00A4;  6'd37: u = 16'h0490;  6'd38: u = 16'h00A6;
            6'd39: u = 16'h00A7;  6'd40: u = 16'h0401;  6'd41: u = 16'h00A9;
            6'd42: u = 16'h0404;  6'd43: u = 16'h00AB;  6'd44: u = 16'h00AC;
            6'd45: u = 16'h00AD;  6'd46: u = 16'h00AE;  6'd47: u = 16'h0407;
            6'd48: u = 16'h00B0;  6'd49: u = 16'h00B1;  6'd50: u = 16'h0406;
            6'd51: u = 16'h0456;  6'd52: u = 16'h0491;  6'd53: u = 16'h00B5;
            6'd54: u = 16'h00B6;  6'd55: u = 16'h00B7;  6'd56: u = 16'h0451;
            6'd57: u = 16'h2116;  6'd58: u = 16'h0454;  6'd59: u = 16'h00BB;
            6'd60: u = 16'h0458;  6'd61: u = 16'h0405;  6'd62: u = 16'h0455;
            6'd63: u = 16'h0457;
            default: u = REPL_UNIT;
        endcase
        return u;
    endfunction

    function automatic t_unit west_high(input logic [4:0] idx);
        t_unit u;
        case (idx)
            5'd0:  u = 16'h20AC;  5'd1:  u = REPL_UNIT; 5'd2:  u = 16'h201A;
            5'd3:  u = 16'h0192;  5'd4:  u = 16'h201E;  5'd5:  u = 16'h2026;
            5'd6:  u = 16'h2020;  5'd7:  u = 16'h2021;  5'd8:  u = 16'h02C6;
            5'd9:  u = 16'h2030;  5'd10: u = 16'h0160;  5'd11: u = 16'h2039;
            5'd12: u = 16'h0152;  5'd13: u = REPL_UNIT; 5'd14: u = 16'h017D;
            5'd15: u = REPL_UNIT; 5'd16: u = REPL_UNIT; 5'd17: u = 16'h2018;
            5'd18: u = 16'h2019;  5'd19: u = 16'h201C;  5'd20: u = 16'h201D;
            5'd21: u = 16'h2022;  5'd22: u = 16'h2013;  5'd23: u = 16'h2014;
            5'd24: u = 16'h02DC;  5'd25: u = 16'h2122;  5'd26: u = 16'h0161;
            5'd27: u = 16'h203A;  5'd28: u = 16'h0153;  5'd29: u = REPL_UNIT;
            5'd30: u = 16'h017E;  5'd31: u = 16'h0178;
            default: u = REPL_UNIT;
        endcase
        return u;
    endfunction

    // one byte through a single-byte code page
    function automatic t_unit single_byte(input logic [1:0] enc, input logic [7:0] b);
        t_unit u;
        if (!b[7]) begin
            u = {8'h00, b};
        end else if (enc == ENC_CYR) begin
            if (!b[6]) begin
                u = cyr_high(b[5:0]);
            end else begin
                u = CYR_BASE + {10'd0, b[5:0]};
            end
        end else begin
            if (b[6:5] == 2'b00) begin
                u = west_high(b[4:0]);
            end else begin
                u = {8'h00, b};
            end
        end
        return u;
    endfunction

endpackage

/* design/mbu16_byte_if.sv */
// input byte channel: valid/ready with one source byte and end-of-text flag
// no dependencies
`timescale 1ns / 1ps

interface mbu16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

/* design/mbu16_unit_if.sv */
// output channel: valid/ready with one utf-16 code unit and run-last flag
// no dependencies
`timescale 1ns / 1ps

interface mbu16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        run_last;

    modport source (output valid, output code_unit, output run_last, input ready);
    modport sink   (input valid, input code_unit, input run_last, output ready);
endinterface

/* design/mbu16_cfg_if.sv */
// configuration write channel: valid/ready with the source_encoding value
// no dependencies
`timescale 1ns / 1ps

interface mbu16_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] source_encoding;

    modport source (output valid, output source_encoding, input ready);
    modport sink   (input valid, input source_encoding, output ready);
endinterface

/* design/mbu16_decode.sv */
// combinational decode of one byte: code page or utf-8 step, up to four units
// depends on mbu16_pkg
`timescale 1ns / 1ps

module mbu16_decode (
    input  logic [1:0]          i_enc,
    input  mbu16_pkg::t_seq     i_state,
    input  logic [7:0]          i_data_byte,
    input  logic                i_last,
    output mbu16_pkg::t_seq     o_state,
    output mbu16_pkg::t_dec_res o_res
);

    always_comb begin
        logic        pend;
        logic        cont;
        logic [20:0] acc;
        logic [20:0] v;
        logic [1:0]  need1;
        logic [1:0]  taken1;
        logic [1:0]  p;
        logic        multi;
        mbu16_pkg::t_seq     nst;
        mbu16_pkg::t_dec_res res;

        pend   = (i_state.need != 2'd0);
        cont   = (i_data_byte[7:6] == 2'b10);
        acc    = {i_state.pcp[14:0], i_data_byte[5:0]};
        v      = acc - mbu16_pkg::SUPP_BASE;
        need1  = i_state.need - 2'd1;
        taken1 = i_state.taken + 2'd1;
        p      = pend ? taken1 : 2'd0;
        multi  = 1'b0;
        nst    = '0;
        for (int k = 0; k < mbu16_pkg::UNITS_MAX; k++) begin
            res.units[k] = mbu16_pkg::REPL_UNIT;
        end
        res.count = 3'd0;

        if (i_enc != mbu16_pkg::ENC_UTF8) begin
            res.units[0] = mbu16_pkg::single_byte(i_enc, i_data_byte);
            res.count    = 3'd1;
            nst          = i_state;
        end else if (pend && cont) begin
            if (need1 == 2'd0) begin
                // sequence complete
                if (acc[20:16] != 5'd0) begin
                    res.units[0] = mbu16_pkg::HI_SURR_BASE + {5'd0, v[20:10]};
                    res.units[1] = {mbu16_pkg::LO_SURR_TAG, v[9:0]};
                    res.count    = 3'd2;
                end else begin
                    res.units[0] = acc[15:0];
                    res.count    = 3'd1;
                end
            end else if (i_last) begin
                // unfinished at end of text: lead plus every continuation
                res.count = 3'd1 + {1'b0, taken1};
            end else begin
                nst.pcp   = acc;
                nst.need  = need1;
                nst.taken = taken1;
            end
        end else begin
            // any broken sequence was flushed ahead (p replacements), then this byte: ascii, lead or replacement
            if (!i_data_byte[7]) begin
                res.units[p] = {8'h00, i_data_byte};
            end else if (i_data_byte[7:5] == 3'b110) begin
                multi    = 1'b1;
                nst.pcp  = {16'd0, i_data_byte[4:0]};
                nst.need = 2'd1;
            end else if (i_data_byte[7:4] == 4'b1110) begin
                multi    = 1'b1;
                nst.pcp  = {17'd0, i_data_byte[3:0]};
                nst.need = 2'd2;
            end else if (i_data_byte[7:3] == 5'b11110) begin
                multi    = 1'b1;
                nst.pcp  = {18'd0, i_data_byte[2:0]};
                nst.need = 2'd3;
            end
            if (multi && !i_last) begin
                res.count = {1'b0, p};
            end else begin
                res.count = {1'b0, p} + 3'd1;
                nst       = '0;
            end
        end

        o_state = nst;
        o_res   = res;
    end

endmodule

/* design/mbu16_out_buf.sv */
// result register holding all units of one item, drained one unit per cycle while o_unit is ready
// depends on mbu16_pkg and mbu16_unit_if
`timescale 1ns / 1ps

module mbu16_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  mbu16_pkg::t_dec_res i_res,
    output logic                o_can_load,
    mbu16_unit_if.source        o_unit
);

    logic                                   r_valid;
    logic [mbu16_pkg::UNITS_MAX-1:0][15:0] r_units;
    logic [2:0]                             r_cnt;
    logic [1:0]                             r_idx;
    logic                                   last_unit;
    logic                                   take;

    assign last_unit  = ({1'b0, r_idx} == (r_cnt - 3'd1));
    assign take       = r_valid && o_unit.ready;
    assign o_can_load = !r_valid || (take && last_unit);

    assign o_unit.valid     = r_valid;
    assign o_unit.code_unit = r_units[r_idx];
    assign o_unit.run_last  = last_unit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= (i_res.count != 3'd0);
            r_idx   <= 2'd0;
        end else if (take) begin
            if (last_unit) begin
                r_valid <= 1'b0;
            end
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_units <= i_res.units;
            r_cnt   <= i_res.count;
        end
    end

`ifndef SYNTHESIS
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_idx} < r_cnt))
        else $error("unit index beyond item count");
    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_cnt != 3'd0 && r_cnt <= 3'd4))
        else $error("held item count out of range");
`endif

endmodule

/* design/multibyte_to_utf16_decoder_top.sv */
// top level of the multibyte to utf-16 decoder: input register, sequence
// state, decode logic and result buffer; depends on mbu16_pkg, the three
// channel interfaces, mbu16_decode and mbu16_out_buf
`timescale 1ns / 1ps

// usage
//   i_byte  : one source byte per item plus end_of_text on the final byte
//   o_unit  : utf-16 code units; run_last marks the last unit of a byte
//   i_cfg   : source_encoding write (0 cyrillic page, 1 or 3 western page,
//             2 utf-8); always ready, also drops any pending utf-8 sequence,
//             write only while no item is in flight
// order: a byte is registered in the input register, then decoded into the result
//   buffer, from which its first unit shows on o_unit
// throughput: one byte per cycle while every byte yields at most one unit and o_unit is ready;
//   a byte giving several units (up to four: surrogate pairs, replacement runs)
//   holds the result buffer until all are taken, the output port is the limit
// bytes that yield no unit (utf-8 leads, continuations) pass through and
//   show nothing on o_unit
// reset: synchronous active low; selects the cyrillic page, clears the
//   sequence state and empties both stages
// stall: when o_unit.ready is low the result buffer holds, the input
//   register fills, and i_byte.ready drops until the buffer drains
module multibyte_to_utf16_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mbu16_byte_if.sink  i_byte,
    mbu16_cfg_if.sink   i_cfg,
    mbu16_unit_if.source o_unit
);

    // encoding register and utf-8 sequence state
    logic [1:0]          r_enc;
    mbu16_pkg::t_seq     r_state;
    mbu16_pkg::t_seq     n_state;

    // input register stage
    logic                r_s1_valid;
    logic [7:0]          r_s1_byte;
    logic                r_s1_last;

    mbu16_pkg::t_dec_res dec_res;
    logic                can_load;
    logic                s1_take;
    logic                in_take;

    assign s1_take      = r_s1_valid && can_load;
    assign i_byte.ready = !r_s1_valid || can_load;
    assign in_take      = i_byte.valid && i_byte.ready;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_take) begin
            r_s1_valid <= 1'b1;
        end else if (s1_take) begin
            r_s1_valid <= 1'b0;
        end
    end

    // payload of the input stage, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_byte <= i_byte.data_byte;
            r_s1_last <= i_byte.end_of_text;
        end
    end

    // a config write wins over decode; the user must write it only while idle, the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enc   <= mbu16_pkg::ENC_CYR;
            r_state <= '0;
        end else if (i_cfg.valid) begin
            r_enc   <= i_cfg.source_encoding;
            r_state <= '0;
        end else if (s1_take) begin
            r_state <= n_state;
        end
    end

    mbu16_decode u_decode (
        .i_enc       (r_enc),
        .i_state     (r_state),
        .i_data_byte (r_s1_byte),
        .i_last      (r_s1_last),
        .o_state     (n_state),
        .o_res       (dec_res)
    );

    mbu16_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (s1_take),
        .i_res      (dec_res),
        .o_can_load (can_load),
        .o_unit     (o_unit)
    );

`ifndef SYNTHESIS
    a_cfg_clears_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid && i_cfg.ready |=> (r_state.need == 2'd0))
        else $error("config write left a sequence pending");
    a_seq_only_utf8: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.need != 2'd0) |-> (r_enc == mbu16_pkg::ENC_UTF8))
        else $error("sequence pending outside utf-8 mode");
`endif

endmodule
